// File: sv/rfc3339_timestamp_to_unix_ms_top_macros.svh
// Assertion macros for the RFC 3339 timestamp converter.
// Depends on nothing; included by the top level only.
`ifndef RFC3339_TIMESTAMP_TO_UNIX_MS_TOP_MACROS_SVH
`define RFC3339_TIMESTAMP_TO_UNIX_MS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rts assertion failed");
`define RTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rts assertion failed");
`else
`define RTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define RTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/rts_pkg.sv
// Shared types, constants and tables for the RFC 3339 timestamp converter.
// Used by the top level, queue, parser and converter; depends on nothing.
`default_nettype none

package rts_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [2:0] ERR_NONE           = 3'd0;
   localparam logic [2:0] ERR_FORMAT         = 3'd1;
   localparam logic [2:0] ERR_DIGIT          = 3'd2;
   localparam logic [2:0] ERR_RANGE          = 3'd3;
   localparam logic [2:0] ERR_FRACTION       = 3'd4;
   localparam logic [2:0] ERR_OFFSET_RANGE   = 3'd5;
   localparam logic [2:0] ERR_OFFSET_MISSING = 3'd6;
   localparam logic [2:0] ERR_TRAILING       = 3'd7;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_T_UP  = 8'h54;
   localparam logic [7:0] CHAR_T_LO  = 8'h74;
   localparam logic [7:0] CHAR_Z_UP  = 8'h5A;
   localparam logic [7:0] CHAR_Z_LO  = 8'h7A;

   localparam logic [5:0] HEAD_CHARS    = 6'd19;
   localparam logic [5:0] MIN_LENGTH    = 6'd20;
   localparam logic [5:0] POS_LIMIT     = 6'd63;
   localparam logic [3:0] MAX_FRACTION  = 4'd7;
   localparam logic [3:0] MILLI_DIGITS  = 4'd3;
   localparam logic [3:0] COUNT_LIMIT   = 4'd15;
   localparam logic [3:0] OFFSET_CHARS  = 4'd6;
   localparam logic [6:0] MAX_ZONE_HOUR = 7'd14;
   localparam logic [6:0] MAX_HOUR      = 7'd23;
   localparam logic [6:0] MAX_MINSEC    = 7'd59;

   // floor(x / 100) == (x * 5243) >> 19 for x below 43699
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic signed [23:0] DAY_BIAS   = 24'sd865565;
   localparam logic signed [27:0] MS_PER_DAY = 28'sd86400000;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_FRACTION,
      PH_ZULU,
      PH_OFFSET
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHECK,
      BK_DIV100,
      BK_DIV400,
      BK_DAYS,
      BK_TOTAL,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic            length_ok;
      logic [2:0]      first_error;
      logic [2:0]      tail_error;
      phase_type       phase;
      logic [3:0]      fraction_digits;
      logic [9:0]      millis;
      logic [3:0][3:0] year_bcd;
      logic [6:0]      month;
      logic [6:0]      day;
      logic [6:0]      hour;
      logic [6:0]      minute;
      logic [6:0]      second;
      logic            zone_sign;
      logic [6:0]      zone_hour;
      logic [6:0]      zone_minute;
      logic [3:0]      zone_chars;
      logic [1:0]      zone_flags;
   } record_type;

   function automatic logic [4:0] month_limit(input logic [6:0] month, input logic leap);
      logic [4:0] lim;
      unique case (month)
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: lim = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                    lim = 5'd30;
         7'd2:                                       lim = leap ? 5'd29 : 5'd28;
         default:                                    lim = 5'd0;
      endcase
      return lim;
   endfunction

   // days from March 1 to the first of the month
   function automatic logic [8:0] days_before(input logic [6:0] month);
      logic [8:0] d;
      unique case (month)
         7'd3:    d = 9'd0;
         7'd4:    d = 9'd31;
         7'd5:    d = 9'd61;
         7'd6:    d = 9'd92;
         7'd7:    d = 9'd122;
         7'd8:    d = 9'd153;
         7'd9:    d = 9'd184;
         7'd10:   d = 9'd214;
         7'd11:   d = 9'd245;
         7'd12:   d = 9'd275;
         7'd1:    d = 9'd306;
         7'd2:    d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: sv/rts_channels.sv
// Valid/ready channel interfaces for request characters and results.
// Depends on nothing.
`default_nettype none

interface rts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   modport source (output valid, char_code, last_char, input ready);
   modport sink (input valid, char_code, last_char, output ready);
endinterface

interface rts_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   logic [2:0]         error_code;
   logic signed [48:0] unix_millis;
   modport source (output valid, valid_res, error_code, unix_millis, input ready);
   modport sink (input valid, valid_res, error_code, unix_millis, output ready);
endinterface

`default_nettype wire

// File: sv/rfc3339_timestamp_to_unix_ms_top.sv
// Top level of the RFC 3339 timestamp to Unix milliseconds converter.
// Depends on rts_pkg, rts_channels, rts_queue, rts_front, rts_back and the macro header.
//
// Usage:
// - req_port carries one text character per transaction (char_code) and
//   last_char on the final character of a timestamp. Characters are taken one
//   per cycle while the record queue has room.
// - rsp_port gives one transaction per timestamp: valid_res, error_code and
//   unix_millis (zero when error_code is not zero).
// - A parsed timestamp passes the converter states check, div100, div400,
//   days and total before its result; on an error, check goes straight to
//   output. The converter handles one record at a time, set by its multi-step epoch sequencer.
// - Parsing runs ahead of the converter through a QueueDepth-record queue;
//   req_port.ready drops only when that queue is full.
// - A result waits in the output register while rsp_port.ready is low; the
//   parser keeps taking characters until the queue fills.
// - Synchronous reset clears the parser, the queue and the sequencer; no
//   partial timestamp survives it.
`default_nettype none
`include "rfc3339_timestamp_to_unix_ms_top_macros.svh"

module rfc3339_timestamp_to_unix_ms_top #(
   parameter int unsigned QueueDepth = rts_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   rts_req_if.sink   req_port,
   rts_rsp_if.source rsp_port
);

   logic                push_valid;
   logic                push_ready;
   rts_pkg::record_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   rts_pkg::record_type pop_data;

   rts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rts_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_port  (rsp_port)
   );

   `RTS_ASSERT_IMP(a_push_has_room, clock, reset, push_valid, push_ready)
   `RTS_ASSERT_IMP(a_ok_flag_matches_code, clock, reset, rsp_port.valid, rsp_port.valid_res == (rsp_port.error_code == rts_pkg::ERR_NONE))
   `RTS_ASSERT_IMP(a_error_zero_millis, clock, reset, rsp_port.valid && (rsp_port.error_code != rts_pkg::ERR_NONE), rsp_port.unix_millis == '0)
   `RTS_ASSERT_NEXT(a_pop_starts_work, clock, reset, pop_valid && pop_ready, !rsp_port.valid)

endmodule

`default_nettype wire

// File: sv/rts_queue.sv
// Small register queue of parsed timestamp records between parser and converter.
// Depends on rts_pkg.
`default_nettype none

module rts_queue #(
   parameter int unsigned Depth = rts_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  rts_pkg::record_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output rts_pkg::record_type pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   rts_pkg::record_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: sv/rts_front.sv
// Character parser: takes one character per transaction, accumulates fields and
// flags, and pushes one record per timestamp. Depends on rts_pkg, rts_channels.
`default_nettype none

module rts_front (
   input  logic                clock,
   input  logic                reset,
   rts_req_if.sink             req_port,
   output logic                push_valid,
   input  logic                push_ready,
   output rts_pkg::record_type push_data
);

   logic                 accept;
   logic                 is_digit;
   logic [3:0]           digit;
   logic [7:0]           c;
   logic                 sep_pos;
   logic                 sep_bad;

   logic [5:0]           pos_ff, pos_in;
   rts_pkg::phase_type   phase_ff, phase_in;
   logic [3:0][3:0]      year_bcd_ff, year_bcd_in;
   logic [6:0]           month_ff, month_in;
   logic [6:0]           day_ff, day_in;
   logic [6:0]           hour_ff, hour_in;
   logic [6:0]           minute_ff, minute_in;
   logic [6:0]           second_ff, second_in;
   logic [9:0]           millis_ff, millis_in;
   logic [3:0]           frac_ff, frac_in;
   logic                 zone_sign_ff, zone_sign_in;
   logic [6:0]           zone_hour_ff, zone_hour_in;
   logic [6:0]           zone_minute_ff, zone_minute_in;
   logic [3:0]           zone_chars_ff, zone_chars_in;
   logic [1:0]           zone_flags_ff, zone_flags_in;
   logic [2:0]           first_error_ff, first_error_in;
   logic [2:0]           tail_error_ff, tail_error_in;

   logic                 off_sign;
   logic [6:0]           off_hour;
   logic [6:0]           off_minute;
   logic [3:0]           off_chars;
   logic [1:0]           off_flags;

   assign c        = req_port.char_code;
   assign accept   = req_port.valid && req_port.ready;
   assign is_digit = (c >= rts_pkg::CHAR_ZERO) && (c <= rts_pkg::CHAR_NINE);
   assign digit    = is_digit ? c[3:0] : 4'd0;

   assign req_port.ready = push_ready;
   assign push_valid     = accept && req_port.last_char;

   // one step of the numeric offset +HH:MM
   always_comb begin
      off_sign   = zone_sign_ff;
      off_hour   = zone_hour_ff;
      off_minute = zone_minute_ff;
      off_flags  = zone_flags_ff;
      unique case (zone_chars_ff)
         4'd0: begin
            if (c == rts_pkg::CHAR_MINUS) begin
               off_sign = 1'b1;
            end else if (c != rts_pkg::CHAR_PLUS) begin
               off_flags[0] = 1'b1;
            end
         end
         4'd1, 4'd2: begin
            if (!is_digit) off_flags[1] = 1'b1;
            off_hour = 7'(zone_hour_ff * 7'd10 + {3'b0, digit});
         end
         4'd3: begin
            if (c != rts_pkg::CHAR_COLON) off_flags[0] = 1'b1;
         end
         4'd4, 4'd5: begin
            if (!is_digit) off_flags[1] = 1'b1;
            off_minute = 7'(zone_minute_ff * 7'd10 + {3'b0, digit});
         end
         default: ;
      endcase
      off_chars = (zone_chars_ff == rts_pkg::COUNT_LIMIT) ? zone_chars_ff
                                                          : zone_chars_ff + 4'd1;
   end

   always_comb begin
      pos_in         = (pos_ff == rts_pkg::POS_LIMIT) ? pos_ff : pos_ff + 6'd1;
      phase_in       = phase_ff;
      year_bcd_in    = year_bcd_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      millis_in      = millis_ff;
      frac_in        = frac_ff;
      zone_sign_in   = zone_sign_ff;
      zone_hour_in   = zone_hour_ff;
      zone_minute_in = zone_minute_ff;
      zone_chars_in  = zone_chars_ff;
      zone_flags_in  = zone_flags_ff;
      first_error_in = first_error_ff;
      tail_error_in  = tail_error_ff;
      sep_pos        = 1'b0;
      sep_bad        = 1'b0;

      unique case (phase_ff)
         rts_pkg::PH_HEAD: begin
            if (pos_ff < rts_pkg::HEAD_CHARS) begin
               unique case (pos_ff)
                  6'd4, 6'd7: begin
                     sep_pos = 1'b1;
                     sep_bad = (c != rts_pkg::CHAR_MINUS);
                  end
                  6'd10: begin
                     sep_pos = 1'b1;
                     sep_bad = (c != rts_pkg::CHAR_T_UP) && (c != rts_pkg::CHAR_T_LO);
                  end
                  6'd13, 6'd16: begin
                     sep_pos = 1'b1;
                     sep_bad = (c != rts_pkg::CHAR_COLON);
                  end
                  default: ;
               endcase
               if (sep_bad) begin
                  first_error_in = rts_pkg::ERR_FORMAT;
               end else if (!sep_pos) begin
                  if (!is_digit && first_error_ff == rts_pkg::ERR_NONE) begin
                     first_error_in = rts_pkg::ERR_DIGIT;
                  end
                  unique case (pos_ff)
                     6'd0, 6'd1, 6'd2, 6'd3: year_bcd_in[pos_ff[1:0]] = digit;
                     6'd5, 6'd6:   month_in  = 7'(month_ff * 7'd10 + {3'b0, digit});
                     6'd8, 6'd9:   day_in    = 7'(day_ff * 7'd10 + {3'b0, digit});
                     6'd11, 6'd12: hour_in   = 7'(hour_ff * 7'd10 + {3'b0, digit});
                     6'd14, 6'd15: minute_in = 7'(minute_ff * 7'd10 + {3'b0, digit});
                     default:      second_in = 7'(second_ff * 7'd10 + {3'b0, digit});
                  endcase
               end
            end else if (c == rts_pkg::CHAR_DOT) begin
               phase_in = rts_pkg::PH_FRACTION;
            end else if (c == rts_pkg::CHAR_Z_UP || c == rts_pkg::CHAR_Z_LO) begin
               phase_in = rts_pkg::PH_ZULU;
            end else begin
               phase_in       = rts_pkg::PH_OFFSET;
               zone_sign_in   = off_sign;
               zone_hour_in   = off_hour;
               zone_minute_in = off_minute;
               zone_chars_in  = off_chars;
               zone_flags_in  = off_flags;
            end
         end
         rts_pkg::PH_FRACTION: begin
            if (is_digit) begin
               if (frac_ff < rts_pkg::MILLI_DIGITS) begin
                  millis_in = 10'(millis_ff * 10'd10 + {6'b0, digit});
               end
               if (frac_ff != rts_pkg::COUNT_LIMIT) frac_in = frac_ff + 4'd1;
            end else begin
               if (frac_ff == 4'd0 || frac_ff > rts_pkg::MAX_FRACTION) begin
                  tail_error_in = rts_pkg::ERR_FRACTION;
               end
               if (c == rts_pkg::CHAR_Z_UP || c == rts_pkg::CHAR_Z_LO) begin
                  phase_in = rts_pkg::PH_ZULU;
               end else begin
                  phase_in       = rts_pkg::PH_OFFSET;
                  zone_sign_in   = off_sign;
                  zone_hour_in   = off_hour;
                  zone_minute_in = off_minute;
                  zone_chars_in  = off_chars;
                  zone_flags_in  = off_flags;
               end
            end
         end
         rts_pkg::PH_ZULU: begin
            if (tail_error_ff == rts_pkg::ERR_NONE) tail_error_in = rts_pkg::ERR_TRAILING;
         end
         rts_pkg::PH_OFFSET: begin
            zone_sign_in   = off_sign;
            zone_hour_in   = off_hour;
            zone_minute_in = off_minute;
            zone_chars_in  = off_chars;
            zone_flags_in  = off_flags;
         end
      endcase
   end

   always_comb begin
      push_data.length_ok       = (pos_in >= rts_pkg::MIN_LENGTH);
      push_data.first_error     = first_error_in;
      push_data.tail_error      = tail_error_in;
      push_data.phase           = phase_in;
      push_data.fraction_digits = frac_in;
      push_data.millis          = millis_in;
      push_data.year_bcd        = year_bcd_in;
      push_data.month           = month_in;
      push_data.day             = day_in;
      push_data.hour            = hour_in;
      push_data.minute          = minute_in;
      push_data.second          = second_in;
      push_data.zone_sign       = zone_sign_in;
      push_data.zone_hour       = zone_hour_in;
      push_data.zone_minute     = zone_minute_in;
      push_data.zone_chars      = zone_chars_in;
      push_data.zone_flags      = zone_flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push_valid) begin
         pos_ff         <= '0;
         phase_ff       <= rts_pkg::PH_HEAD;
         year_bcd_ff    <= '0;
         month_ff       <= '0;
         day_ff         <= '0;
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         millis_ff      <= '0;
         frac_ff        <= '0;
         zone_sign_ff   <= 1'b0;
         zone_hour_ff   <= '0;
         zone_minute_ff <= '0;
         zone_chars_ff  <= '0;
         zone_flags_ff  <= '0;
         first_error_ff <= rts_pkg::ERR_NONE;
         tail_error_ff  <= rts_pkg::ERR_NONE;
      end else if (accept) begin
         pos_ff         <= pos_in;
         phase_ff       <= phase_in;
         year_bcd_ff    <= year_bcd_in;
         month_ff       <= month_in;
         day_ff         <= day_in;
         hour_ff        <= hour_in;
         minute_ff      <= minute_in;
         second_ff      <= second_in;
         millis_ff      <= millis_in;
         frac_ff        <= frac_in;
         zone_sign_ff   <= zone_sign_in;
         zone_hour_ff   <= zone_hour_in;
         zone_minute_ff <= zone_minute_in;
         zone_chars_ff  <= zone_chars_in;
         zone_flags_ff  <= zone_flags_in;
         first_error_ff <= first_error_in;
         tail_error_ff  <= tail_error_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/rts_back.sv
// Converter: checks a parsed record, picks the error code and computes Unix
// milliseconds over several steps. Depends on rts_pkg, rts_channels.
`default_nettype none

module rts_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  rts_pkg::record_type pop_data,
   rts_rsp_if.source           rsp_port
);

   rts_pkg::back_state_type state_ff, state_in;
   rts_pkg::record_type     rec_ff;

   logic [13:0]        yy_ff, yy_in;
   logic signed [12:0] mins_ff, mins_in;
   logic [9:0]         ms_ff, ms_in;
   logic [8:0]         doy_ff, doy_in;
   logic [6:0]         c100_ff, c100_in;
   logic [4:0]         c400_ff, c400_in;
   logic signed [18:0] secs_ff, secs_in;
   logic signed [28:0] tod_ff, tod_in;
   logic signed [23:0] days_ff, days_in;
   logic               valid_res_ff;
   logic [2:0]         error_code_ff;
   logic signed [48:0] unix_millis_ff;

   logic [1:0]         lo_mod4, hi_mod4;
   logic               leap;
   logic [4:0]         lim;
   logic               date_ok;
   logic [2:0]         verdict;
   logic [13:0]        year_bin;
   logic [12:0]        zone_total;
   logic signed [12:0] off;
   logic [26:0]        prod100, prod400;
   logic signed [51:0] wide;

   always_comb begin
      lo_mod4 = 2'({rec_ff.year_bcd[2][0], 1'b0} + rec_ff.year_bcd[3][1:0]);
      hi_mod4 = 2'({rec_ff.year_bcd[0][0], 1'b0} + rec_ff.year_bcd[1][1:0]);
      leap    = (lo_mod4 == 2'd0)
                && ((rec_ff.year_bcd[2] != 4'd0) || (rec_ff.year_bcd[3] != 4'd0)
                    || (hi_mod4 == 2'd0));
      lim     = rts_pkg::month_limit(rec_ff.month, leap);
      date_ok = (rec_ff.month >= 7'd1) && (rec_ff.month <= 7'd12)
                && (rec_ff.day >= 7'd1) && (rec_ff.day <= {2'b0, lim})
                && (rec_ff.hour <= rts_pkg::MAX_HOUR)
                && (rec_ff.minute <= rts_pkg::MAX_MINSEC)
                && (rec_ff.second <= rts_pkg::MAX_MINSEC);

      priority if (!rec_ff.length_ok) begin
         verdict = rts_pkg::ERR_FORMAT;
      end else if (rec_ff.first_error != rts_pkg::ERR_NONE) begin
         verdict = rec_ff.first_error;
      end else if (!date_ok) begin
         verdict = rts_pkg::ERR_RANGE;
      end else if (rec_ff.phase == rts_pkg::PH_FRACTION) begin
         verdict = (rec_ff.fraction_digits == 4'd0
                    || rec_ff.fraction_digits > rts_pkg::MAX_FRACTION)
                   ? rts_pkg::ERR_FRACTION : rts_pkg::ERR_OFFSET_MISSING;
      end else if (rec_ff.tail_error != rts_pkg::ERR_NONE) begin
         verdict = rec_ff.tail_error;
      end else if (rec_ff.phase == rts_pkg::PH_ZULU) begin
         verdict = rts_pkg::ERR_NONE;
      end else if (rec_ff.zone_chars != rts_pkg::OFFSET_CHARS || rec_ff.zone_flags[0]) begin
         verdict = rts_pkg::ERR_OFFSET_MISSING;
      end else if (rec_ff.zone_flags[1]) begin
         verdict = rts_pkg::ERR_DIGIT;
      end else if (rec_ff.zone_hour > rts_pkg::MAX_ZONE_HOUR
                   || rec_ff.zone_minute > rts_pkg::MAX_MINSEC
                   || (rec_ff.zone_hour == rts_pkg::MAX_ZONE_HOUR
                       && rec_ff.zone_minute != 7'd0)) begin
         verdict = rts_pkg::ERR_OFFSET_RANGE;
      end else begin
         verdict = rts_pkg::ERR_NONE;
      end
   end

   // check step: year shifted to start in March, minutes of day less the zone offset, scaled fraction, day of that year
   always_comb begin
      year_bin = 14'({10'b0, rec_ff.year_bcd[0]} * 14'd1000
                     + {10'b0, rec_ff.year_bcd[1]} * 14'd100
                     + {10'b0, rec_ff.year_bcd[2]} * 14'd10
                     + {10'b0, rec_ff.year_bcd[3]});
      yy_in    = year_bin + 14'd400 - {13'b0, (rec_ff.month <= 7'd2)};
      zone_total = 13'({6'b0, rec_ff.zone_hour} * 13'd60 + {6'b0, rec_ff.zone_minute});
      if (rec_ff.phase != rts_pkg::PH_OFFSET) begin
         off = '0;
      end else if (rec_ff.zone_sign) begin
         off = -$signed(zone_total);
      end else begin
         off = $signed(zone_total);
      end
      mins_in = 13'($signed({6'b0, rec_ff.hour}) * 13'sd60
                    + $signed({6'b0, rec_ff.minute}) - off);
      if (rec_ff.fraction_digits == 4'd1) begin
         ms_in = 10'(rec_ff.millis * 10'd100);
      end else if (rec_ff.fraction_digits == 4'd2) begin
         ms_in = 10'(rec_ff.millis * 10'd10);
      end else begin
         ms_in = rec_ff.millis;
      end
      doy_in = 9'(rts_pkg::days_before(rec_ff.month) + {2'b0, rec_ff.day} - 9'd1);
   end

   always_comb begin
      prod100 = {13'b0, yy_ff} * {14'b0, rts_pkg::RECIP_100};
      c100_in = prod100[rts_pkg::RECIP_SHIFT +: 7];
      secs_in = 19'(mins_ff * 19'sd60 + $signed({12'b0, rec_ff.second}));
      prod400 = {15'b0, yy_ff[13:2]} * {14'b0, rts_pkg::RECIP_100};
      c400_in = prod400[rts_pkg::RECIP_SHIFT +: 5];
      tod_in  = 29'(secs_ff * 29'sd1000 + $signed({19'b0, ms_ff}));
      days_in = 24'($signed({10'b0, yy_ff}) * 24'sd365
                    + $signed({12'b0, yy_ff[13:2]})
                    - $signed({17'b0, c100_ff})
                    + $signed({19'b0, c400_ff})
                    + $signed({15'b0, doy_ff})
                    - rts_pkg::DAY_BIAS);
      wide    = days_ff * rts_pkg::MS_PER_DAY + tod_ff;
   end

   always_comb begin
      state_in  = state_ff;
      pop_ready = (state_ff == rts_pkg::BK_IDLE);
      unique case (state_ff)
         rts_pkg::BK_IDLE:   if (pop_valid) state_in = rts_pkg::BK_CHECK;
         rts_pkg::BK_CHECK:  state_in = (verdict == rts_pkg::ERR_NONE) ? rts_pkg::BK_DIV100
                                                                       : rts_pkg::BK_OUT;
         rts_pkg::BK_DIV100: state_in = rts_pkg::BK_DIV400;
         rts_pkg::BK_DIV400: state_in = rts_pkg::BK_DAYS;
         rts_pkg::BK_DAYS:   state_in = rts_pkg::BK_TOTAL;
         rts_pkg::BK_TOTAL:  state_in = rts_pkg::BK_OUT;
         rts_pkg::BK_OUT:    if (rsp_port.ready) state_in = rts_pkg::BK_IDLE;
         default:            state_in = rts_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rts_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rts_pkg::BK_IDLE: begin
            if (pop_valid) rec_ff <= pop_data;
         end
         rts_pkg::BK_CHECK: begin
            yy_ff          <= yy_in;
            mins_ff        <= mins_in;
            ms_ff          <= ms_in;
            doy_ff         <= doy_in;
            valid_res_ff   <= (verdict == rts_pkg::ERR_NONE);
            error_code_ff  <= verdict;
            unix_millis_ff <= '0;
         end
         rts_pkg::BK_DIV100: begin
            c100_ff <= c100_in;
            secs_ff <= secs_in;
         end
         rts_pkg::BK_DIV400: begin
            c400_ff <= c400_in;
            tod_ff  <= tod_in;
         end
         rts_pkg::BK_DAYS: begin
            days_ff <= days_in;
         end
         rts_pkg::BK_TOTAL: begin
            unix_millis_ff <= wide[48:0];
         end
         default: ;
      endcase
   end

   assign rsp_port.valid       = (state_ff == rts_pkg::BK_OUT);
   assign rsp_port.valid_res   = valid_res_ff;
   assign rsp_port.error_code  = error_code_ff;
   assign rsp_port.unix_millis = unix_millis_ff;

endmodule

`default_nettype wire
